// ===== rtl/tki_pkg.sv =====
// Shared types and constants for the top-K insertion list.
`default_nettype none

package tki_pkg;

  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned IN_COORD_W = 16;
  localparam int unsigned RANK_W     = 4;
  localparam int unsigned POS_W      = 5;

  localparam logic signed [VALUE_W-1:0] MIN_SCORE = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef enum logic {
    OP_OFFER = 1'b0,
    OP_READ  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CMP,
    B_EXEC
  } back_state_e;

  // One classified item as it waits between front and back
  typedef struct packed {
    op_e                        op;
    logic signed [VALUE_W-1:0]  value;
    logic [IN_COORD_W-1:0]      x;
    logic [IN_COORD_W-1:0]      y;
    logic [IN_COORD_W-1:0]      z;
    logic [RANK_W-1:0]          read_rank;
  } cmd_t;

  // Back sequencer controls to the list store
  typedef struct packed {
    logic cmp;
    logic apply;
  } store_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/tki_front.sv =====
// Front part: accepts items, classifies them and holds them in a two-entry queue.
`default_nettype none

module tki_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic                          func_i,
  input  wire logic signed [tki_pkg::VALUE_W-1:0] cand_value_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0] cand_x_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0] cand_y_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0] cand_z_i,
  input  wire logic [tki_pkg::RANK_W-1:0]    read_rank_i,
  output logic                               cmd_valid_o,
  output tki_pkg::cmd_t                      cmd_o,
  input  wire logic                          cmd_pop_i
);
  import tki_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;
  cmd_t       cmd_in;

  assign full        = (count_q == 2'd2);
  assign cmd_valid_o = (count_q != 2'd0);
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  // Classify the incoming item
  always_comb begin
    cmd_in.op        = func_i ? OP_READ : OP_OFFER;
    cmd_in.value     = cand_value_i;
    cmd_in.x         = cand_x_i;
    cmd_in.y         = cand_y_i;
    cmd_in.z         = cand_z_i;
    cmd_in.read_rank = read_rank_i;
  end

  // Store the item in the free slot
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= !wr_ptr_q;
      if (do_pop)  rd_ptr_q <= !rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tki_store.sv =====
// Sorted list cells: parallel compare, shift-insert and rank readout.
`default_nettype none

module tki_store #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire tki_pkg::store_ctrl_t               ctrl_i,
  input  wire logic signed [tki_pkg::VALUE_W-1:0] cand_value_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     cand_x_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     cand_y_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     cand_z_i,
  input  wire logic [tki_pkg::RANK_W-1:0]         read_rank_i,
  output logic                                    hit_o,
  output logic [tki_pkg::POS_W-1:0]               pos_o,
  output logic signed [tki_pkg::VALUE_W-1:0]      rd_value_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          rd_x_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          rd_y_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          rd_z_o
);
  import tki_pkg::*;

  localparam int unsigned PW   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned RD_N = (LIST_DEPTH < (1 << RANK_W)) ? LIST_DEPTH : (1 << RANK_W);

  logic signed [VALUE_W-1:0] val_q [LIST_DEPTH];
  logic [COORD_BITS-1:0]     x_q   [LIST_DEPTH];
  logic [COORD_BITS-1:0]     y_q   [LIST_DEPTH];
  logic [COORD_BITS-1:0]     z_q   [LIST_DEPTH];
  logic [LIST_DEPTH-1:0]     gt_q;
  logic [LIST_DEPTH-1:0]     gt_prev;
  logic [LIST_DEPTH-1:0]     first;
  logic [PW-1:0]             pos;
  logic [COORD_BITS-1:0]     cx, cy, cz;

  assign cx      = COORD_BITS'(cand_x_i);
  assign cy      = COORD_BITS'(cand_y_i);
  assign cz      = COORD_BITS'(cand_z_i);
  assign gt_prev = gt_q << 1;
  assign first   = gt_q & ~gt_prev;
  // The list stays sorted, so the compare vector is a run of ones up to the tail
  assign hit_o   = gt_q[LIST_DEPTH-1];
  assign pos_o   = POS_W'(pos);

  // Encode the insertion rank from the first exceeded entry
  always_comb begin
    pos = hit_o ? '0 : PW'(LIST_DEPTH);
    for (int j = 0; j < LIST_DEPTH; j++) begin
      if (first[j]) pos = pos | PW'(j);
    end
  end

  // Register the per-cell compare against the candidate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gt_q <= '0;
    end else if (ctrl_i.cmp) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        gt_q[j] <= (cand_value_i > val_q[j]);
      end
    end
  end

  // Shift the tail down one rank and drop the candidate into its slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        val_q[j] <= MIN_SCORE;
        x_q[j]   <= '0;
        y_q[j]   <= '0;
        z_q[j]   <= '0;
      end
    end else if (ctrl_i.apply) begin
      for (int j = 0; j < LIST_DEPTH; j++) begin
        if (gt_prev[j]) begin
          val_q[j] <= val_q[(j == 0) ? 0 : j - 1];
          x_q[j]   <= x_q[(j == 0) ? 0 : j - 1];
          y_q[j]   <= y_q[(j == 0) ? 0 : j - 1];
          z_q[j]   <= z_q[(j == 0) ? 0 : j - 1];
        end else if (gt_q[j]) begin
          val_q[j] <= cand_value_i;
          x_q[j]   <= cx;
          y_q[j]   <= cy;
          z_q[j]   <= cz;
        end
      end
    end
  end

  // Select the entry at the requested rank; ranks past the list read zero
  always_comb begin
    rd_value_o = '0;
    rd_x_o     = '0;
    rd_y_o     = '0;
    rd_z_o     = '0;
    for (int j = 0; j < RD_N; j++) begin
      if (read_rank_i == RANK_W'(j)) begin
        rd_value_o = val_q[j];
        rd_x_o     = IN_COORD_W'(x_q[j]);
        rd_y_o     = IN_COORD_W'(y_q[j]);
        rd_z_o     = IN_COORD_W'(z_q[j]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tki_back.sv =====
// Back part: sequences compare and update on the store and holds the result register.
`default_nettype none

module tki_back (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cmd_valid_i,
  input  wire tki_pkg::cmd_t                      cmd_i,
  output logic                                    cmd_pop_o,
  output tki_pkg::cmd_t                           cur_o,
  output tki_pkg::store_ctrl_t                    ctrl_o,
  input  wire logic                               hit_i,
  input  wire logic [tki_pkg::POS_W-1:0]          pos_i,
  input  wire logic signed [tki_pkg::VALUE_W-1:0] rd_value_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     rd_x_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     rd_y_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     rd_z_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic                                    inserted_o,
  output logic [tki_pkg::POS_W-1:0]               rank_o,
  output logic signed [tki_pkg::VALUE_W-1:0]      out_value_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          out_x_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          out_y_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          out_z_o
);
  import tki_pkg::*;

  back_state_e state_q, state_d;
  cmd_t        cur_q;
  logic        out_valid_q;
  logic        out_free;
  logic        load_cmd;
  logic        load_out;

  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;
  assign cur_o    = cur_q;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and store controls
  always_comb begin
    state_d      = state_q;
    load_cmd     = 1'b0;
    load_out     = 1'b0;
    ctrl_o.cmp   = 1'b0;
    ctrl_o.apply = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          load_cmd = 1'b1;
          state_d  = B_CMP;
        end
      end
      B_CMP: begin
        ctrl_o.cmp = (cur_q.op == OP_OFFER);
        state_d    = B_EXEC;
      end
      B_EXEC: begin
        if (out_free) begin
          load_out     = 1'b1;
          ctrl_o.apply = (cur_q.op == OP_OFFER);
          if (cmd_valid_i) begin
            load_cmd = 1'b1;
            state_d  = B_CMP;
          end else begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  assign cmd_pop_o = load_cmd;

  // Hold the item under work
  always_ff @(posedge clk_i) begin
    if (load_cmd) cur_q <= cmd_i;
  end

  // Result register: offers report insertion, reads report the entry
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      if (cur_q.op == OP_OFFER) begin
        inserted_o  <= hit_i;
        rank_o      <= pos_i;
        out_value_o <= '0;
        out_x_o     <= '0;
        out_y_o     <= '0;
        out_z_o     <= '0;
      end else begin
        inserted_o  <= 1'b0;
        rank_o      <= '0;
        out_value_o <= rd_value_i;
        out_x_o     <= rd_x_i;
        out_y_o     <= rd_y_i;
        out_z_o     <= rd_z_i;
      end
    end
  end

  // Track whether a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/top_k_insert_with_coords_unit.sv =====
// Top-K sorted insertion list with coordinates: top level.
//
// Input side is a queue: drive the item fields with push high; it is taken at a
// clock edge where full is low. func 0 offers a candidate score with its x, y, z
// coordinates, func 1 reads the entry stored at read_rank (0 is the largest).
// Result side is a queue too: while empty is low the oldest result sits on the
// result ports and is taken at an edge with pop high. Every item gives one result:
// an offer reports inserted and the rank taken (LIST_DEPTH, masked to 5 bits, when
// dropped); a read reports the score and coordinates, zero past the list.
// From idle, an item goes through the item register, compare register and result
// register before its result appears. Each item spends a compare step and a
// shift-insert step on the list cells; the next item starts as the last finishes.
// A two-entry queue sits between input and sequencer, so items keep being taken
// while a result waits; when pop stays low the sequencer holds its finished item
// and full rises once the queue fills. Reset empties both sides and sets every
// entry to the most negative score with zero coordinates.
`default_nettype none

module top_k_insert_with_coords_unit #(
  parameter int unsigned LIST_DEPTH = 16,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic                               func_i,
  input  wire logic signed [tki_pkg::VALUE_W-1:0] cand_value_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     cand_x_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     cand_y_i,
  input  wire logic [tki_pkg::IN_COORD_W-1:0]     cand_z_i,
  input  wire logic [tki_pkg::RANK_W-1:0]         read_rank_i,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic                                    inserted_o,
  output logic [tki_pkg::POS_W-1:0]               rank_o,
  output logic signed [tki_pkg::VALUE_W-1:0]      out_value_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          out_x_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          out_y_o,
  output logic [tki_pkg::IN_COORD_W-1:0]          out_z_o
);
  import tki_pkg::*;

  logic                      cmd_valid;
  cmd_t                      cmd;
  logic                      cmd_pop;
  cmd_t                      cur;
  store_ctrl_t               ctrl;
  logic                      hit;
  logic [POS_W-1:0]          pos;
  logic signed [VALUE_W-1:0] rd_value;
  logic [IN_COORD_W-1:0]     rd_x, rd_y, rd_z;

  // Accept and queue items
  tki_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .func_i       (func_i),
    .cand_value_i (cand_value_i),
    .cand_x_i     (cand_x_i),
    .cand_y_i     (cand_y_i),
    .cand_z_i     (cand_z_i),
    .read_rank_i  (read_rank_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .cmd_pop_i    (cmd_pop)
  );

  // List cells
  tki_store #(
    .LIST_DEPTH (LIST_DEPTH),
    .COORD_BITS (COORD_BITS)
  ) u_store (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .cand_value_i (cur.value),
    .cand_x_i     (cur.x),
    .cand_y_i     (cur.y),
    .cand_z_i     (cur.z),
    .read_rank_i  (cur.read_rank),
    .hit_o        (hit),
    .pos_o        (pos),
    .rd_value_o   (rd_value),
    .rd_x_o       (rd_x),
    .rd_y_o       (rd_y),
    .rd_z_o       (rd_z)
  );

  // Sequence items and hold results
  tki_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cur_o       (cur),
    .ctrl_o      (ctrl),
    .hit_i       (hit),
    .pos_i       (pos),
    .rd_value_i  (rd_value),
    .rd_x_i      (rd_x),
    .rd_y_i      (rd_y),
    .rd_z_i      (rd_z),
    .empty       (empty),
    .pop         (pop),
    .inserted_o  (inserted_o),
    .rank_o      (rank_o),
    .out_value_o (out_value_o),
    .out_x_o     (out_x_o),
    .out_y_o     (out_y_o),
    .out_z_o     (out_z_o)
  );

endmodule

`default_nettype wire
